### rtl/mrp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the motion record and playback core.
// No dependencies.
package mrp_pkg;

    localparam int FRAMES   = 1024;
    localparam int CHANNELS = 4;

    localparam int ADDR_W    = $clog2(FRAMES);
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int POS_W     = 64;
    localparam int TRQ_W     = 32;
    localparam int EN_W      = 4;
    localparam int IDX_OUT_W = 11;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 32;

    localparam logic [TRQ_W-1:0] PLAY_TORQUE_RST = 32'h8080_8080;
    localparam logic [TRQ_W-1:0] FULL_TORQUE     = 32'h8080_8080;

    typedef enum logic [2:0] {
        MODE_STOP  = 3'd0,
        MODE_OFF   = 3'd1,
        MODE_REC   = 3'd2,
        MODE_PLAY  = 3'd3,
        MODE_TRAIN = 3'd4,
        MODE_LOOP  = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_MODES = 8'd0,
        REG_PLAY_TORQUE   = 8'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CH_RECORD = 2'd0,
        CH_PLAY   = 2'd1,
        CH_HOLD   = 2'd2,
        CH_FREE   = 2'd3
    } ch_mode_t;

    localparam logic [2:0] BTN_STOP   = 3'd0;
    localparam logic [2:0] BTN_OFF    = 3'd1;
    localparam logic [2:0] BTN_RECORD = 3'd2;
    localparam logic [2:0] BTN_PLAY   = 3'd3;
    localparam logic [2:0] BTN_LOOP   = 3'd4;
    localparam logic [2:0] BTN_TRAIN  = 3'd5;
    localparam logic [2:0] BTN_SAVE   = 3'd6;
    localparam logic [2:0] BTN_LOAD   = 3'd7;

    function automatic logic [POS_W-1:0] pos_mask_f();
        logic [POS_W-1:0] m;
        m = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            m[16*c +: 16] = 16'hFFFF;
        end
        return m;
    endfunction

    function automatic logic [TRQ_W-1:0] trq_mask_f();
        logic [TRQ_W-1:0] m;
        m = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            m[8*c +: 8] = 8'hFF;
        end
        return m;
    endfunction

    function automatic logic [EN_W-1:0] en_all_f();
        logic [EN_W-1:0] m;
        m = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            m[c] = 1'b1;
        end
        return m;
    endfunction

    localparam logic [POS_W-1:0] POS_MASK = pos_mask_f();
    localparam logic [TRQ_W-1:0] TRQ_MASK = trq_mask_f();
    localparam logic [EN_W-1:0]  EN_ALL   = en_all_f();

endpackage

### rtl/motion_record_playback_core.sv
`timescale 1ns / 1ps
// Motion record and playback core: mode control, frame memory and result register.
// Depends on mrp_pkg.
//
// Pipeline: an accepted beat loads stage 2; the result register loads when stage 2 advances.
// Throughput: one beat per cycle unless output stalls; the single read port reads once a beat.
// Reset: control state, counters and output registers clear at once; the frame memory is not
// swept, a high-water count makes entries never written since reset read as zero.
module motion_record_playback_core
    import mrp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 stop_button,
    input  logic                 off_button,
    input  logic                 record_button,
    input  logic                 play_button,
    input  logic                 loop_button,
    input  logic                 train_button,
    input  logic                 save_button,
    input  logic                 load_button,
    input  logic [POS_W-1:0]     positions_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_W-1:0]     positions_out,
    output logic [TRQ_W-1:0]     torque_out,
    output logic [EN_W-1:0]      enable_out,
    output logic [2:0]           mode_state,
    output logic [IDX_OUT_W-1:0] frame_index,
    output logic [IDX_OUT_W-1:0] frames_recorded
);

    // configuration
    logic [7:0]       channel_modes_reg;
    logic [TRQ_W-1:0] play_torque_reg;

    // stage 1 control state
    mode_t            mode_reg;
    logic [7:0]       pend_reg;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] pidx_reg;
    logic [CNT_W-1:0] hwm_reg;
    logic [TRQ_W-1:0] torque_reg;
    logic [EN_W-1:0]  enable_reg;

    // stage 2
    logic              s2_valid_reg;
    mode_t             s2_mode_reg;
    logic [POS_W-1:0]  s2_pin_reg;
    logic              s2_wr_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [TRQ_W-1:0]  s2_torque_reg;
    logic [EN_W-1:0]   s2_enable_reg;
    logic [CNT_W-1:0]  s2_pidx_reg;
    logic [CNT_W-1:0]  s2_total_reg;

    // memory read side
    logic [POS_W-1:0] frame_mem [FRAMES];
    logic [POS_W-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic             fwd_reg;
    logic [POS_W-1:0] fwd_data_reg;

    // output register
    logic                 out_valid_reg;
    logic [POS_W-1:0]     out_pos_reg;
    logic [TRQ_W-1:0]     out_torque_reg;
    logic [EN_W-1:0]      out_enable_reg;
    mode_t                out_mode_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic [IDX_OUT_W-1:0] out_total_reg;

    logic in_acc;
    logic s2_adv;

    // command decode results
    logic [7:0]       btn;
    logic [7:0]       rel;
    logic             found;
    logic [2:0]       act_b;
    mode_t            mode_next;
    logic [7:0]       pend_next;
    logic [CNT_W-1:0] total_c;
    logic [CNT_W-1:0] pidx_c;
    logic [TRQ_W-1:0] torque_c;
    logic [EN_W-1:0]  enable_c;

    // mode action results
    logic [CNT_W-1:0]  total_next;
    logic [CNT_W-1:0]  pidx_next;
    logic [CNT_W-1:0]  hwm_next;
    logic [TRQ_W-1:0]  torque_next;
    logic [EN_W-1:0]   enable_next;
    logic [CNT_W-1:0]  raddr_full;
    logic [ADDR_W-1:0] raddr;
    logic              wr_next;
    logic [POS_W-1:0]  pin;

    // stage 2 merge
    logic [POS_W-1:0] old_frame;
    logic [POS_W-1:0] upd_frame;
    logic [POS_W-1:0] pos_next;

    assign cfg_ready = 1'b1;
    assign s2_adv    = s2_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s2_valid_reg || s2_adv;
    assign in_acc    = in_valid && in_ready;
    assign pin       = positions_in & POS_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_modes_reg <= '0;
            play_torque_reg   <= PLAY_TORQUE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CHANNEL_MODES: channel_modes_reg <= cfg_data[7:0];
                REG_PLAY_TORQUE:   play_torque_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // command decode: released button, then held stop/off, then press capture
    always_comb
    begin
        btn = {load_button, save_button, train_button, loop_button,
               play_button, record_button, off_button, stop_button};
        rel       = ~btn & pend_reg;
        found     = 1'b0;
        act_b     = BTN_STOP;
        mode_next = mode_reg;
        pend_next = pend_reg;
        total_c   = total_reg;
        pidx_c    = pidx_reg;
        torque_c  = torque_reg;
        enable_c  = enable_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (!found && rel[i])
            begin
                found = 1'b1;
                act_b = 3'(i);
            end
        end
        if (found)
        begin
            pend_next[act_b] = 1'b0;
            unique case (act_b)
                BTN_STOP: mode_next = MODE_STOP;
                BTN_OFF:  mode_next = MODE_OFF;
                BTN_RECORD:
                begin
                    mode_next = MODE_REC;
                    torque_c  = '0;
                    enable_c  = '0;
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (channel_modes_reg[2*c +: 2] == CH_PLAY
                            || channel_modes_reg[2*c +: 2] == CH_HOLD)
                        begin
                            enable_c[c]       = 1'b1;
                            torque_c[8*c +: 8] = play_torque_reg[8*c +: 8];
                        end
                    end
                    total_c = '0;
                    pidx_c  = '0;
                end
                BTN_PLAY, BTN_LOOP, BTN_TRAIN:
                begin
                    mode_next = (act_b == BTN_PLAY) ? MODE_PLAY
                              : (act_b == BTN_LOOP) ? MODE_LOOP : MODE_TRAIN;
                    torque_c  = play_torque_reg & TRQ_MASK;
                    enable_c  = EN_ALL;
                    pidx_c    = '0;
                end
                default:
                begin
                    mode_next = MODE_STOP;
                    pidx_c    = '0;
                end
            endcase
        end
        else if (btn[BTN_STOP])
        begin
            pend_next[BTN_STOP] = 1'b0;
            mode_next           = MODE_STOP;
        end
        else if (btn[BTN_OFF])
        begin
            pend_next[BTN_OFF] = 1'b0;
            mode_next          = MODE_OFF;
        end
        else if (btn[BTN_RECORD])
            pend_next[BTN_RECORD] = 1'b1;
        else if (btn[BTN_PLAY])
            pend_next[BTN_PLAY] = 1'b1;
        else if (btn[BTN_TRAIN])
            pend_next[BTN_TRAIN] = 1'b1;
        else if (btn[BTN_SAVE])
            pend_next[BTN_SAVE] = 1'b1;
        else if (btn[BTN_LOAD])
            pend_next[BTN_LOAD] = 1'b1;
        else if (btn[BTN_LOOP])
            pend_next[BTN_LOOP] = 1'b1;
    end

    // mode action: counters, torque, enable and the frame access
    always_comb
    begin
        total_next  = total_c;
        pidx_next   = pidx_c;
        hwm_next    = hwm_reg;
        torque_next = torque_c;
        enable_next = enable_c;
        raddr_full  = pidx_c;
        wr_next     = 1'b0;
        unique case (mode_next)
            MODE_STOP:
            begin
                pidx_next   = '0;
                torque_next = FULL_TORQUE & TRQ_MASK;
                enable_next = EN_ALL;
            end
            MODE_OFF:
            begin
                pidx_next   = '0;
                torque_next = '0;
                enable_next = '0;
            end
            MODE_REC:
            begin
                raddr_full = total_c;
                if (total_c < CNT_W'(FRAMES) && pin != '0)
                begin
                    wr_next    = 1'b1;
                    total_next = total_c + 1'b1;
                    if (total_c >= hwm_reg)
                        hwm_next = total_c + 1'b1;
                end
                pidx_next = total_next;
            end
            MODE_PLAY:
            begin
                if (total_c != '0 && pidx_c < total_c - 1'b1)
                    pidx_next = pidx_c + 1'b1;
            end
            MODE_LOOP:
            begin
                if (total_c != '0 && pidx_c < total_c - 1'b1)
                    pidx_next = pidx_c + 1'b1;
                else
                    pidx_next = '0;
            end
            default: ;
        endcase
        raddr = raddr_full[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_STOP;
            pend_reg   <= '0;
            total_reg  <= '0;
            pidx_reg   <= '0;
            hwm_reg    <= '0;
            torque_reg <= '0;
            enable_reg <= '0;
        end
        else if (in_acc)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            total_reg  <= total_next;
            pidx_reg   <= pidx_next;
            hwm_reg    <= hwm_next;
            torque_reg <= torque_next;
            enable_reg <= enable_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (in_acc)
            s2_valid_reg <= 1'b1;
        else if (s2_adv)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s2_mode_reg   <= mode_next;
            s2_pin_reg    <= pin;
            s2_wr_reg     <= wr_next;
            s2_addr_reg   <= raddr;
            s2_torque_reg <= torque_next;
            s2_enable_reg <= enable_next;
            s2_pidx_reg   <= pidx_next;
            s2_total_reg  <= total_next;
        end
    end

    // frame memory: one write from stage 2, one read per accepted beat
    always_ff @(posedge clk)
    begin
        if (s2_adv && s2_wr_reg)
            frame_mem[s2_addr_reg] <= upd_frame;
        if (in_acc)
        begin
            rd_data_reg  <= frame_mem[raddr];
            rd_valid_reg <= raddr_full < hwm_reg;
            fwd_reg      <= s2_adv && s2_wr_reg && (s2_addr_reg == raddr);
            fwd_data_reg <= upd_frame;
        end
    end

    // stage 2: merge stored frame with the live frame per mode; train mode holds the last output
    always_comb
    begin
        old_frame = fwd_reg ? fwd_data_reg : (rd_valid_reg ? rd_data_reg : '0);
        upd_frame = old_frame;
        pos_next  = s2_pin_reg;
        case (s2_mode_reg)
            MODE_REC:
            begin
                if (s2_wr_reg)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (channel_modes_reg[2*c +: 2] == CH_RECORD)
                            upd_frame[16*c +: 16] = s2_pin_reg[16*c +: 16];
                        else if (channel_modes_reg[2*c +: 2] == CH_PLAY)
                            pos_next[16*c +: 16] = old_frame[16*c +: 16];
                    end
                end
            end
            MODE_PLAY, MODE_LOOP: pos_next = old_frame & POS_MASK;
            MODE_TRAIN:           pos_next = out_pos_reg;
            default:              pos_next = s2_pin_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_pos_reg    <= '0;
            out_torque_reg <= '0;
            out_enable_reg <= '0;
            out_mode_reg   <= MODE_STOP;
            out_idx_reg    <= '0;
            out_total_reg  <= '0;
        end
        else
        begin
            if (s2_adv)
            begin
                out_valid_reg  <= 1'b1;
                out_pos_reg    <= pos_next;
                out_torque_reg <= s2_torque_reg;
                out_enable_reg <= s2_enable_reg;
                out_mode_reg   <= s2_mode_reg;
                out_idx_reg    <= IDX_OUT_W'(s2_pidx_reg);
                out_total_reg  <= IDX_OUT_W'(s2_total_reg);
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign positions_out   = out_pos_reg;
    assign torque_out      = out_torque_reg;
    assign enable_out      = out_enable_reg;
    assign mode_state      = out_mode_reg;
    assign frame_index     = out_idx_reg;
    assign frames_recorded = out_total_reg;

    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(FRAMES) && total_reg <= hwm_reg)
        else $error("frame count beyond store or high-water mark");

    a_wr_only_rec: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_wr_reg |-> s2_mode_reg == MODE_REC)
        else $error("frame write outside record mode");

    a_no_stop_off_pend: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg[BTN_STOP] && !pend_reg[BTN_OFF])
        else $error("stop or off release flag set");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_adv |=> s2_valid_reg && $stable(s2_addr_reg))
        else $error("stage 2 lost a stalled beat");

endmodule
